// ===== hw/rtl/tfs_pkg.sv =====
// Shared types, constants and helpers for the telemetry frame stuffer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tfs_pkg;

    // Byte codes on the line.
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] TYPE_RESET = 8'h10;
    localparam logic [7:0] CHECK_BASE = 8'hFF;
    localparam logic [7:0] VOID_BYTE  = 8'h00;

    // Request kinds carried on tuser.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_VOID = 1'b1;

    // Seven raw bytes per frame (type, id, value) and the check byte after them.
    localparam int RAW_BYTES = 7;
    localparam int IDX_W     = 3;
    localparam logic [IDX_W-1:0] CHECK_IDX = 3'd7;

    // One classified request as it sits in the queue.
    typedef struct packed {
        logic                      mode;
        logic [RAW_BYTES-1:0][7:0] raw;
    } frame_req_t;

    // Queue status seen by the front end.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // 8-bit sum with end-around carry.
    function automatic logic [7:0] add_sum(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, sum} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

// ===== hw/rtl/tfs_queue.sv =====
// Two-entry request queue between the front end and the byte sequencer.
// Depends on tfs_pkg for the request type.
`timescale 1ns / 1ps

module tfs_queue
    import tfs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  frame_req_t    push_req,
    input  logic          pop,
    output frame_req_t    head_req,
    output logic          head_valid,
    output queue_status_t status
);

    frame_req_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign head_req     = mem_reg[rd_ptr_reg];
    assign head_valid   = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// ===== hw/rtl/tfs_front.sv =====
// Front end: holds the type register, accepts requests and packs them into
// queue entries. Depends on tfs_pkg.
`timescale 1ns / 1ps

module tfs_front
    import tfs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,
    input  logic [0:0]    s_tuser,
    input  queue_status_t q_status,
    output logic          push,
    output frame_req_t    push_req
);

    logic [7:0] frame_type_reg;

    // Type register, to be written only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_type_reg <= TYPE_RESET;
        end else if (cfg_wr_en) begin
            frame_type_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // Byte order on the line: type, id low to high, value low to high.
    always_comb begin
        push_req.mode   = s_tuser[0];
        push_req.raw[0] = frame_type_reg;
        push_req.raw[1] = s_tdata[7:0];
        push_req.raw[2] = s_tdata[15:8];
        push_req.raw[3] = s_tdata[23:16];
        push_req.raw[4] = s_tdata[31:24];
        push_req.raw[5] = s_tdata[39:32];
        push_req.raw[6] = s_tdata[47:40];
    end

endmodule

// ===== hw/rtl/tfs_back.sv =====
// Back end: walks one queued request byte by byte, escapes reserved codes,
// keeps the running check sum and drives the output register. Depends on tfs_pkg.
`timescale 1ns / 1ps

module tfs_back
    import tfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  frame_req_t head_req,
    input  logic       head_valid,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic             esc_reg,    esc_next;
    logic [7:0]       sum_reg,    sum_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    logic       step;
    logic       is_void;
    logic       at_check;
    logic [7:0] cur_byte;
    logic       need_esc;

    assign is_void  = (head_req.mode == MODE_VOID);
    assign at_check = (idx_reg == CHECK_IDX);
    assign step     = head_valid && (!m_valid_reg || m_tready);

    // Unescaped byte at the current position.
    always_comb begin
        if (at_check) begin
            cur_byte = is_void ? CHECK_BASE : (CHECK_BASE - sum_reg);
        end else begin
            cur_byte = is_void ? VOID_BYTE : head_req.raw[idx_reg];
        end
    end

    assign need_esc = !is_void && ((cur_byte == ESC_BYTE) || (cur_byte == FLAG_BYTE));

    // Sequencer: one output byte per step, a reserved code takes two steps.
    always_comb begin
        idx_next     = idx_reg;
        esc_next     = esc_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        pop          = 1'b0;
        if (step) begin
            m_valid_next = 1'b1;
            if (need_esc && !esc_reg) begin
                m_data_next = ESC_BYTE;
                m_last_next = 1'b0;
                esc_next    = 1'b1;
            end else begin
                m_data_next = esc_reg ? (cur_byte ^ ESC_XOR) : cur_byte;
                m_last_next = at_check;
                esc_next    = 1'b0;
                if (at_check) begin
                    idx_next = '0;
                    sum_next = 8'd0;
                    pop      = 1'b1;
                end else begin
                    idx_next = idx_reg + 3'd1;
                    sum_next = add_sum(sum_reg, cur_byte);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            esc_reg     <= 1'b0;
            sum_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            esc_reg     <= esc_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/telemetry_frame_stuffer.sv =====
// Top level of the telemetry frame stuffer: front end, request queue, back end.
// Depends on tfs_pkg, tfs_front, tfs_queue and tfs_back.
`timescale 1ns / 1ps
//
// Usage:
// - The input stream carries one send request per item: tuser[0] selects a
//   data frame (0) or the fixed void frame (1); tdata holds the id and value.
// - The output stream carries one line byte per item, tlast on the final byte.
// - A data frame is the type byte, id and value low byte first, then the
//   check byte; 0x7D and 0x7E go out as 0x7D and the byte XOR 0x20.
// - A void frame is seven zero bytes followed by 0xFF.
// - cfg_wr_en/cfg_wr_data write the type byte; write it only while idle.
// An accepted request enters the queue; if that was empty and the output
//   register free, the sequencer loads its first byte into that register.
// The sequencer sends one output byte per cycle while a request is queued
//   and m_tready is high; a frame is 8 to 16 bytes, 8 plus one per escape.
// The two-entry queue lets the next request be accepted while a frame is
//   still being sent. When the receiver stalls, the output byte holds and the
//   sequencer waits; the input stalls once the queue is full.
// Reset clears the queue, the sequencer and the output valid, and sets the
//   type byte to 0x10.
//

module telemetry_frame_stuffer
    import tfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] data_id, [47:16] value
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    queue_status_t q_status;
    logic          push;
    frame_req_t    push_req;
    logic          pop;
    frame_req_t    head_req;
    logic          head_valid;

    // Accept and classify requests.
    tfs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_status    (q_status),
        .push        (push),
        .push_req    (push_req)
    );

    // Decouple the two sides.
    tfs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .head_req   (head_req),
        .head_valid (head_valid),
        .status     (q_status)
    );

    // Serialize frames onto the output stream.
    tfs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_req   (head_req),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== hw/rtl/tfs_checker.sv =====
// Port-level checker for the telemetry frame stuffer, bound to the top level.
// Depends on the top-level ports and on tfs_pkg for the byte codes.
`timescale 1ns / 1ps

module tfs_checker
    import tfs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // A stalled output item holds its byte and its end flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // The flag code never appears raw on the line.
    a_no_raw_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != FLAG_BYTE))
        else $error("raw flag byte on the line");

    // An escape byte is always followed by its partner, so it never ends a frame.
    a_esc_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == ESC_BYTE) |-> !m_tlast)
        else $error("frame ends on an escape byte");

    // Reset leaves the output empty and the input open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input blocked after reset");

endmodule

bind telemetry_frame_stuffer tfs_checker u_tfs_checker (.*);

// ===== bench/tb_telemetry_frame_stuffer.sv =====
// Self-checking bench for telemetry_frame_stuffer: random send requests, line bytes
// predicted per frame and compared with the output stream, both sides stalling.
// Depends on tfs_pkg and the telemetry_frame_stuffer RTL.
`timescale 1ns / 1ps

module tb_telemetry_frame_stuffer;
    import tfs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_TAIL   = 24;

    // One send request as it waits for the input channel.
    typedef struct {
        logic        mode;
        logic [15:0] data_id;
        logic [31:0] value;
    } send_req_t;

    // One byte expected on the line.
    typedef struct {
        logic [7:0] line_byte;
        logic       ends_frame;
    } line_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;   // [15:0] data_id, [47:16] value
    logic [0:0]  s_tuser     = '0;   // [0] mode
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;

    send_req_t  pending_reqs[$];
    line_byte_t line_bytes_due[$];
    send_req_t  req_on_bus;
    logic [7:0] type_byte_model = TYPE_RESET;
    int         error_count = 0;
    int         cycle_count = 0;
    int         send_gap = 0;
    int         send_calm = 0;
    int         recv_stall = 0;
    int         recv_calm = 0;

    telemetry_frame_stuffer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Wait cycles for one item; calm stretches give back-to-back traffic.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Check byte: 0xFF minus the end-around-carry sum of type, id and value bytes.
    function automatic logic [7:0] frame_check(input logic [7:0] type_byte,
                                               input logic [15:0] data_id,
                                               input logic [31:0] value);
        logic [55:0] raw;
        int          acc;
        raw = {value, data_id, type_byte};
        acc = 0;
        for (int i = 0; i < 7; i++) begin
            acc = acc + raw[i*8 +: 8];
            if (acc > 255) acc = acc - 255;
        end
        return CHECK_BASE - acc[7:0];
    endfunction

    // Queue one line byte, escaping 0x7D and 0x7E when asked.
    task automatic queue_line_byte(input logic [7:0] b, input logic stuff, input logic ends);
        line_byte_t lb;
        if (stuff && (b == ESC_BYTE || b == FLAG_BYTE)) begin
            lb.line_byte = ESC_BYTE;
            lb.ends_frame = 1'b0;
            line_bytes_due.push_back(lb);
            lb.line_byte = b ^ ESC_XOR;
        end else begin
            lb.line_byte = b;
        end
        lb.ends_frame = ends;
        line_bytes_due.push_back(lb);
    endtask

    // Expected line bytes of the frame that one accepted request produces.
    task automatic encode_frame(input send_req_t r);
        logic [55:0] raw;
        if (r.mode == MODE_VOID) begin
            for (int i = 0; i < 7; i++) queue_line_byte(VOID_BYTE, 1'b0, 1'b0);
            queue_line_byte(CHECK_BASE, 1'b0, 1'b1);
        end else begin
            raw = {r.value, r.data_id, type_byte_model};
            for (int i = 0; i < 7; i++) queue_line_byte(raw[i*8 +: 8], 1'b1, 1'b0);
            queue_line_byte(frame_check(type_byte_model, r.data_id, r.value), 1'b1, 1'b1);
        end
    endtask

    // Adjust the top value byte until the check byte hits the target, if it can.
    function automatic send_req_t aim_check(input send_req_t r, input logic [7:0] target);
        send_req_t t;
        t = r;
        for (int k = 0; k < 256; k++) begin
            t.value[31:24] = k[7:0];
            if (frame_check(type_byte_model, t.data_id, t.value) == target) return t;
        end
        return r;
    endfunction

    function automatic send_req_t make_req(input logic mode, input logic [15:0] data_id,
                                           input logic [31:0] value);
        send_req_t r;
        r.mode = mode;
        r.data_id = data_id;
        r.value = value;
        return r;
    endfunction

    // Random request, biased toward escape bytes and escaped check bytes.
    function automatic send_req_t random_req();
        send_req_t   r;
        logic [47:0] body;
        logic [7:0]  b;
        body = 48'({$urandom, $urandom});
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                b = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
                body[i*8 +: 8] = b;
            end
        end
        r = make_req(($urandom_range(0, 7) == 0) ? MODE_VOID : MODE_DATA,
                     body[15:0], body[47:16]);
        if (r.mode == MODE_DATA && $urandom_range(0, 7) == 0)
            r = aim_check(r, $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
        error_count++;
    endtask

    // Sender: one item per request, with a random gap after each handshake.
    always @(posedge aclk) begin
        logic sending;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            sending = s_tvalid;
            if (s_tvalid && s_tready) begin
                encode_frame(req_on_bus);
                sending = 1'b0;
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tdata <= {req_on_bus.value, req_on_bus.data_id};
                    s_tuser <= req_on_bus.mode;
                    sending = 1'b1;
                    send_gap = draw_wait(send_calm);
                end
            end
            s_tvalid <= sending;
        end
    end

    // Receiver: compare each line byte with the oldest expectation, then draw a random stall.
    always @(posedge aclk) begin
        line_byte_t want;
        logic       ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            ready_next = m_tready;
            if (m_tvalid && m_tready) begin
                if (line_bytes_due.size() == 0) begin
                    report_mismatch("unexpected line byte", 8'h00, m_tdata);
                end else begin
                    want = line_bytes_due.pop_front();
                    if (m_tdata !== want.line_byte)
                        report_mismatch("out_byte", want.line_byte, m_tdata);
                    if (m_tlast !== want.ends_frame)
                        report_mismatch("last", {7'd0, want.ends_frame}, {7'd0, m_tlast});
                end
                recv_stall = draw_wait(recv_calm);
                ready_next = (recv_stall == 0);
            end else if (!m_tready) begin
                if (recv_stall > 0) recv_stall--;
                ready_next = (recv_stall == 0);
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[telemetry_frame_stuffer] ERROR");
            $finish;
        end
    end

    // Hold off until the sender is empty and every frame has been seen.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || line_bytes_due.size() != 0);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_frame_type(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        type_byte_model = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
    endtask

    // Phases: reset type first, then zero, all ones, both escape codes, random.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset type byte.
        pending_reqs.push_back(make_req(MODE_VOID, 16'h0000, 32'h0000_0000));
        pending_reqs.push_back(make_req(MODE_VOID, 16'hFFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h0000, 32'h0000_0000));
        pending_reqs.push_back(make_req(MODE_DATA, 16'hFFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h7E7D, 32'h7D7E_7D7E));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h007D, 32'h0000_0000));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h7E00, 32'h0000_0000));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h1234, 32'h7E00_0000));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h0001, 32'h0000_007D));
        pending_reqs.push_back(make_req(MODE_DATA, 16'h5555, 32'hAAAA_AAAA));
        pending_reqs.push_back(make_req(MODE_DATA, 16'hAAAA, 32'h5555_5555));
        pending_reqs.push_back(aim_check(make_req(MODE_DATA, 16'h0102, 32'h0003_0405), ESC_BYTE));
        pending_reqs.push_back(aim_check(make_req(MODE_DATA, 16'h0102, 32'h0003_0405), FLAG_BYTE));
        pending_reqs.push_back(aim_check(make_req(MODE_DATA, 16'h7D7E, 32'h007D_7E7D), ESC_BYTE));
        pending_reqs.push_back(aim_check(make_req(MODE_DATA, 16'hC0DE, 32'h0012_3456), 8'h00));
        pending_reqs.push_back(aim_check(make_req(MODE_DATA, 16'hC0DE, 32'h0012_3456), 8'hFF));
        pending_reqs.push_back(make_req(MODE_VOID, 16'h7E7D, 32'h7E7D_7E7D));
        queue_random(40);
        wait_idle();

        // Zero type: an all-zero frame sums to zero.
        write_frame_type(8'h00);
        pending_reqs.push_back(make_req(MODE_DATA, 16'h0000, 32'h0000_0000));
        queue_random(35);
        wait_idle();

        write_frame_type(8'hFF);
        pending_reqs.push_back(make_req(MODE_DATA, 16'hFFFF, 32'hFFFF_FFFF));
        queue_random(35);
        wait_idle();

        // Escape codes as the type byte, with frames that escape almost every byte.
        write_frame_type(FLAG_BYTE);
        pending_reqs.push_back(make_req(MODE_DATA, 16'h7D7E, 32'h7E7D_7E7D));
        pending_reqs.push_back(aim_check(make_req(MODE_DATA, 16'h7D7E, 32'h007D_7E7D), FLAG_BYTE));
        queue_random(35);
        wait_idle();

        write_frame_type(ESC_BYTE);
        pending_reqs.push_back(make_req(MODE_DATA, 16'h7E7E, 32'h7D7D_7E7E));
        queue_random(35);
        wait_idle();

        write_frame_type($urandom_range(0, 255));
        queue_random(45);
        wait_idle();

        if (line_bytes_due.size() != 0)
            report_mismatch("line bytes never seen", 8'h00, 8'(line_bytes_due.size()));
        if (error_count == 0) begin
            $display("[telemetry_frame_stuffer] OK");
        end else begin
            $display("[telemetry_frame_stuffer] ERROR");
        end
        $finish;
    end

endmodule
